### sv/rtce_pkg.sv
// Package with shared types, codes and reset constants of the connection engine.
`timescale 1ns / 1ps
package rtce_pkg;

  localparam logic [15:0] WindowReset = 16'd3072;
  localparam logic [15:0] MssReset    = 16'd536;
  localparam logic [31:0] IssReset    = 32'd1;
  localparam logic [15:0] DelayReset  = 16'd100;
  localparam int          QueueDepth  = 2;

  typedef enum logic [3:0] {
    ST_LISTEN    = 4'd0,
    ST_SYNSENT   = 4'd1,
    ST_SYNRCVD   = 4'd2,
    ST_ESTAB     = 4'd3,
    ST_FINW1     = 4'd4,
    ST_FINW2     = 4'd5,
    ST_TIMEWAIT  = 4'd6,
    ST_CLOSED    = 4'd7,
    ST_CLOSEWAIT = 4'd8,
    ST_LASTACK   = 4'd9,
    ST_CLOSING   = 4'd10
  } conn_state_t;

  typedef enum logic [2:0] {
    ACT_OPEN  = 3'd0,
    ACT_TICK  = 3'd1,
    ACT_DATA  = 3'd2,
    ACT_SEG   = 3'd3,
    ACT_CLOSE = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CFG_ROLE   = 3'd0,
    CFG_WINDOW = 3'd1,
    CFG_MSS    = 3'd2,
    CFG_ISS    = 3'd3,
    CFG_DELAY  = 3'd4
  } cfg_index_t;

  localparam logic [2:0] F_SYN = 3'd1;
  localparam logic [2:0] F_ACK = 3'd2;
  localparam logic [2:0] F_FIN = 3'd4;

  localparam logic [1:0] STAT_NONE      = 2'd0;
  localparam logic [1:0] STAT_CONNECTED = 2'd1;
  localparam logic [1:0] STAT_FAILED    = 2'd2;
  localparam logic [1:0] STAT_CLOSED    = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] app_pending_bytes;
    logic [2:0]  net_flags;
    logic [31:0] net_seq;
    logic [31:0] net_ack;
    logic [15:0] net_payload_bytes;
  } req_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  send_flags;
    logic [31:0] tx_seq;
    logic [31:0] send_ack;
    logic [15:0] send_window;
    logic [15:0] send_payload_bytes;
    logic [15:0] deliver_bytes;
    logic        fin_to_app;
    logic [3:0]  link_state;
    logic [1:0]  open_status;
    logic        last;
  } res_t;

endpackage

### sv/reliable_transport_connection_engine.sv
// Top level of the connection engine: request queue, engine and assertions.
// Each request passes the request queue, then its first result is registered.
// Throughput: one request per cycle while the output does not stall and each
// request yields one result; a second result blocks new requests until it moves on.
// Reset (rst_n low, synchronous) returns the connection to listen, clears the
// queue and restores the configuration and connection registers to their defaults.
`timescale 1ns / 1ps
module reliable_transport_connection_engine #(
  parameter int QueueDepth = rtce_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_app_pending_bytes,
  input  logic [2:0]  in_net_flags,
  input  logic [31:0] in_net_seq,
  input  logic [31:0] in_net_ack,
  input  logic [15:0] in_net_payload_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_valid,
  output logic [2:0]  out_send_flags,
  output logic [31:0] out_tx_seq,
  output logic [31:0] out_send_ack,
  output logic [15:0] out_send_window,
  output logic [15:0] out_send_payload_bytes,
  output logic [15:0] out_deliver_bytes,
  output logic        out_fin_to_app,
  output logic [3:0]  out_link_state,
  output logic [1:0]  out_open_status,
  output logic        out_last
);

  rtce_pkg::req_t in_req, q_req;
  rtce_pkg::res_t res;
  logic           q_valid, q_take;

  assign in_req = '{action: in_action, app_pending_bytes: in_app_pending_bytes,
                    net_flags: in_net_flags, net_seq: in_net_seq,
                    net_ack: in_net_ack, net_payload_bytes: in_net_payload_bytes};

  rtce_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req, .q_valid, .q_take, .q_req
  );

  rtce_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_req, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .out_valid, .out_stall, .out_res(res)
  );

  assign out_send_valid         = res.send_valid;
  assign out_send_flags         = res.send_flags;
  assign out_tx_seq             = res.tx_seq;
  assign out_send_ack           = res.send_ack;
  assign out_send_window        = res.send_window;
  assign out_send_payload_bytes = res.send_payload_bytes;
  assign out_deliver_bytes      = res.deliver_bytes;
  assign out_fin_to_app         = res.fin_to_app;
  assign out_link_state         = res.link_state;
  assign out_open_status        = res.open_status;
  assign out_last               = res.last;

  a_idle_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> out_send_flags == 3'd0 && out_last)
    else $error("Result without a segment carries flags or is not final.");

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("Engine took a request from an empty queue.");

  a_non_last_sends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_send_valid && out_open_status == 2'd0)
    else $error("Earlier result lacks a segment or reports status.");

endmodule

### sv/rtce_front.sv
// Front part: a small request queue ahead of the engine.
`timescale 1ns / 1ps
module rtce_front #(
  parameter int Depth = rtce_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rtce_pkg::req_t in_req,
  output logic           q_valid,
  input  logic           q_take,
  output rtce_pkg::req_t q_req
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  rtce_pkg::req_t mem_r [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_stall = (cnt_r == (AW+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_take;
  assign q_req    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? ((rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_req;
  end

endmodule

### sv/rtce_back.sv
// Back part: connection state, segment generation and the result register.
`timescale 1ns / 1ps
module rtce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_take,
  input  rtce_pkg::req_t q_req,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rtce_pkg::res_t out_res
);

  logic        role_r;
  logic [15:0] win_r, mss_r, delay_r;
  logic [31:0] iss_r;

  rtce_pkg::conn_state_t st_r, st_nxt;
  logic        fin_r, fin_nxt;
  logic [31:0] snd_r, snd_nxt, rcv_r, rcv_nxt, una_r, una_nxt;
  logic        ap_r, ap_nxt;
  logic [15:0] tm_r, tm_nxt;

  // Second result of a request that emits two segments waits here.
  logic           hold_v_r;
  rtce_pkg::res_t hold_r;
  logic           ov_r;
  rtce_pkg::res_t o_r;

  logic        e1, e2;
  logic [2:0]  f1, f2;
  logic [31:0] s1, s2, a1, a2;
  logic [15:0] l1, l2, dlv;
  logic        fapp;
  logic [1:0]  stat;
  logic [31:0] inflight, avail32;
  logic [15:0] avail;
  logic        conn;
  logic        out_free, take;
  rtce_pkg::res_t r1, r2;

  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || !out_stall;
  assign take      = q_valid && !hold_v_r && out_free;
  assign q_take    = take;
  assign out_valid = ov_r;
  assign out_res   = o_r;

  always_comb begin
    st_nxt = st_r; fin_nxt = fin_r; snd_nxt = snd_r; rcv_nxt = rcv_r;
    una_nxt = una_r; ap_nxt = ap_r; tm_nxt = tm_r;
    e1 = 1'b0; e2 = 1'b0; f1 = '0; f2 = '0; s1 = '0; s2 = '0; a1 = '0; a2 = '0;
    l1 = '0; l2 = '0; dlv = '0; fapp = 1'b0; stat = rtce_pkg::STAT_NONE;
    conn = (st_r == rtce_pkg::ST_ESTAB) || (st_r == rtce_pkg::ST_FINW1) ||
           (st_r == rtce_pkg::ST_FINW2) || (st_r == rtce_pkg::ST_CLOSEWAIT) ||
           (st_r == rtce_pkg::ST_LASTACK) || (st_r == rtce_pkg::ST_CLOSING);
    inflight = snd_r - una_r;
    avail32 = (inflight >= {16'd0, win_r}) ? 32'd0 : {16'd0, win_r} - inflight;
    if (avail32 > {16'd0, mss_r}) avail32 = {16'd0, mss_r};
    if (avail32 > {16'd0, q_req.app_pending_bytes})
      avail32 = {16'd0, q_req.app_pending_bytes};
    avail = avail32[15:0];
    unique case (q_req.action)
      rtce_pkg::ACT_OPEN: begin
        if (st_r == rtce_pkg::ST_LISTEN || st_r == rtce_pkg::ST_CLOSED) begin
          una_nxt = iss_r; rcv_nxt = '0; ap_nxt = 1'b0; tm_nxt = '0;
          fin_nxt = 1'b0; st_nxt = rtce_pkg::ST_LISTEN; snd_nxt = iss_r;
          if (role_r) begin
            e1 = 1'b1; f1 = rtce_pkg::F_SYN; s1 = iss_r; a1 = '0;
            st_nxt = rtce_pkg::ST_SYNSENT; snd_nxt = iss_r + 32'd1;
          end
        end
      end
      rtce_pkg::ACT_TICK: begin
        if (conn && ap_r) begin
          if (tm_r <= 16'd1) begin
            e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_r;
            ap_nxt = 1'b0; tm_nxt = '0;
          end else begin
            tm_nxt = tm_r - 16'd1;
          end
        end
      end
      rtce_pkg::ACT_DATA: begin
        if ((st_r == rtce_pkg::ST_ESTAB || st_r == rtce_pkg::ST_CLOSEWAIT) &&
            avail != '0) begin
          e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_r; l1 = avail;
          snd_nxt = snd_r + {16'd0, avail}; ap_nxt = 1'b0;
        end
      end
      rtce_pkg::ACT_SEG: begin
        priority if (st_r == rtce_pkg::ST_LISTEN) begin
          if (!role_r) begin
            if (q_req.net_flags == rtce_pkg::F_SYN) begin
              rcv_nxt = q_req.net_seq + 32'd1; st_nxt = rtce_pkg::ST_SYNRCVD;
              e1 = 1'b1; f1 = rtce_pkg::F_SYN | rtce_pkg::F_ACK; s1 = snd_r;
              a1 = q_req.net_seq + 32'd1; snd_nxt = snd_r + 32'd1;
            end else begin
              st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1;
              stat = rtce_pkg::STAT_FAILED;
            end
          end
        end else if (st_r == rtce_pkg::ST_SYNSENT) begin
          if (q_req.net_flags == (rtce_pkg::F_SYN | rtce_pkg::F_ACK) &&
              q_req.net_ack == snd_r) begin
            rcv_nxt = q_req.net_seq + 32'd1; una_nxt = q_req.net_ack;
            e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = q_req.net_seq + 32'd1;
            st_nxt = rtce_pkg::ST_ESTAB; stat = rtce_pkg::STAT_CONNECTED;
          end else begin
            st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1;
            stat = rtce_pkg::STAT_FAILED;
          end
        end else if (st_r == rtce_pkg::ST_SYNRCVD) begin
          if (q_req.net_flags == rtce_pkg::F_ACK && q_req.net_ack == snd_r) begin
            una_nxt = q_req.net_ack; st_nxt = rtce_pkg::ST_ESTAB;
            stat = rtce_pkg::STAT_CONNECTED;
          end else begin
            st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1;
            stat = rtce_pkg::STAT_FAILED;
          end
        end else if (conn && q_req.net_flags[1]) begin
          if (q_req.net_ack > una_r && q_req.net_ack <= snd_r) begin
            una_nxt = q_req.net_ack;
            priority if (st_r == rtce_pkg::ST_FINW1 && q_req.net_ack == snd_r) begin
              st_nxt = rtce_pkg::ST_FINW2;
            end else if (st_r == rtce_pkg::ST_LASTACK && q_req.net_ack == snd_r) begin
              st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1; stat = rtce_pkg::STAT_CLOSED;
            end else if (st_r == rtce_pkg::ST_CLOSING) begin
              st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1; stat = rtce_pkg::STAT_CLOSED;
            end else begin
            end
          end
          if (q_req.net_payload_bytes != '0) begin
            if (q_req.net_seq == rcv_r) begin
              dlv = q_req.net_payload_bytes;
              rcv_nxt = rcv_r + {16'd0, q_req.net_payload_bytes};
              if (ap_r) begin
                e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_nxt;
                ap_nxt = 1'b0; tm_nxt = '0;
              end else begin
                ap_nxt = 1'b1; tm_nxt = delay_r;
              end
            end else begin
              ap_nxt = 1'b0; tm_nxt = '0;
              e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_r;
            end
          end
          if (q_req.net_flags[2] &&
              (q_req.net_seq + {16'd0, q_req.net_payload_bytes}) == rcv_nxt) begin
            fapp = 1'b1;
            rcv_nxt = rcv_nxt + 32'd1; ap_nxt = 1'b0; tm_nxt = '0;
            if (e1) begin
              e2 = 1'b1; f2 = rtce_pkg::F_ACK; s2 = snd_r; a2 = rcv_nxt;
            end else begin
              e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_nxt;
            end
            // The acknowledgement above may already have moved the state.
            priority if (st_nxt == rtce_pkg::ST_ESTAB) begin
              st_nxt = rtce_pkg::ST_CLOSEWAIT;
            end else if (st_nxt == rtce_pkg::ST_FINW1) begin
              st_nxt = rtce_pkg::ST_CLOSING;
            end else if (st_nxt == rtce_pkg::ST_FINW2) begin
              st_nxt = rtce_pkg::ST_CLOSED; fin_nxt = 1'b1; stat = rtce_pkg::STAT_CLOSED;
            end else begin
            end
          end
        end else begin
        end
      end
      rtce_pkg::ACT_CLOSE: begin
        if (conn) begin
          if (ap_r) begin
            e1 = 1'b1; f1 = rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_r;
            ap_nxt = 1'b0; tm_nxt = '0;
          end
          if (st_r == rtce_pkg::ST_ESTAB || st_r == rtce_pkg::ST_CLOSEWAIT) begin
            st_nxt = (st_r == rtce_pkg::ST_ESTAB) ? rtce_pkg::ST_FINW1
                                                  : rtce_pkg::ST_LASTACK;
            snd_nxt = snd_r + 32'd1;
            if (e1) begin
              e2 = 1'b1; f2 = rtce_pkg::F_FIN | rtce_pkg::F_ACK; s2 = snd_r; a2 = rcv_r;
            end else begin
              e1 = 1'b1; f1 = rtce_pkg::F_FIN | rtce_pkg::F_ACK; s1 = snd_r; a1 = rcv_r;
            end
          end
        end
      end
      default: begin
      end
    endcase

    r1 = '0;
    r1.send_valid = e1; r1.send_flags = f1; r1.tx_seq = s1; r1.send_ack = a1;
    r1.send_window = e1 ? win_r : '0; r1.send_payload_bytes = l1;
    r1.link_state = st_nxt;
    r2 = '0;
    r2.send_valid = e2; r2.send_flags = f2; r2.tx_seq = s2; r2.send_ack = a2;
    r2.send_window = e2 ? win_r : '0; r2.send_payload_bytes = l2;
    r2.link_state = st_nxt;
    r2.deliver_bytes = dlv; r2.fin_to_app = fapp; r2.open_status = stat; r2.last = 1'b1;
    if (!e2) begin
      r1.deliver_bytes = dlv; r1.fin_to_app = fapp; r1.open_status = stat; r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r <= 1'b0; win_r <= rtce_pkg::WindowReset; mss_r <= rtce_pkg::MssReset;
      iss_r <= rtce_pkg::IssReset; delay_r <= rtce_pkg::DelayReset;
      st_r <= rtce_pkg::ST_LISTEN; fin_r <= 1'b0; snd_r <= '0; rcv_r <= '0;
      una_r <= '0; ap_r <= 1'b0; tm_r <= '0;
      hold_v_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          rtce_pkg::CFG_ROLE:   role_r  <= cfg_data[0];
          rtce_pkg::CFG_WINDOW: win_r   <= cfg_data[15:0];
          rtce_pkg::CFG_MSS:    mss_r   <= cfg_data[15:0];
          rtce_pkg::CFG_ISS:    iss_r   <= cfg_data;
          rtce_pkg::CFG_DELAY:  delay_r <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (out_free) begin
        if (hold_v_r) begin
          ov_r <= 1'b1; o_r <= hold_r; hold_v_r <= 1'b0;
        end else if (take) begin
          ov_r <= 1'b1; o_r <= r1; hold_v_r <= e2; hold_r <= r2;
          st_r <= st_nxt; fin_r <= fin_nxt; snd_r <= snd_nxt; rcv_r <= rcv_nxt;
          una_r <= una_nxt; ap_r <= ap_nxt; tm_r <= tm_nxt;
        end else begin
          ov_r <= 1'b0;
        end
      end
    end
  end

endmodule

### bench/tb.sv
// Self-checking testbench for the connection engine with its own behavioral predictor.
`timescale 1ns / 1ps
module tb;
  import rtce_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [15:0] in_app_pending_bytes = '0;
  logic [2:0] in_net_flags = '0;
  logic [31:0] in_net_seq = '0;
  logic [31:0] in_net_ack = '0;
  logic [15:0] in_net_payload_bytes = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_send_valid;
  logic [2:0] out_send_flags;
  logic [31:0] out_tx_seq;
  logic [31:0] out_send_ack;
  logic [15:0] out_send_window;
  logic [15:0] out_send_payload_bytes;
  logic [15:0] out_deliver_bytes;
  logic out_fin_to_app;
  logic [3:0] out_link_state;
  logic [1:0] out_open_status;
  logic out_last;

  reliable_transport_connection_engine uut (.*);

  always #5 clk = ~clk;

  logic m_role;
  logic [15:0] m_window, m_mss, m_delay;
  logic [31:0] m_iss;
  conn_state_t m_state;
  logic [31:0] m_snd_nxt, m_rcv_nxt, m_acked;
  logic m_pending;
  logic [15:0] m_timer;

  res_t segment_queue[$];
  res_t expected_results[$];
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int stall_left = 0;
  logic [31:0] peer_isn;
  bit stall_enable = 1'b1;

  function automatic void queue_segment(logic [2:0] flags, logic [15:0] len);
    res_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.send_flags = flags;
    r.tx_seq = m_snd_nxt;
    r.send_ack = m_rcv_nxt;
    r.send_window = m_window;
    r.send_payload_bytes = len;
    if (segment_queue.size() < 2) segment_queue.push_back(r);
  endfunction

  function automatic bit is_connected();
    return m_state inside {ST_ESTAB, ST_FINW1, ST_FINW2, ST_CLOSEWAIT, ST_LASTACK, ST_CLOSING};
  endfunction

  function automatic void predict_connection(req_t q);
    logic [15:0] deliver;
    logic fin_app;
    logic [1:0] status;
    logic [31:0] inflight, avail;
    res_t r;
    int n;
    deliver = '0;
    fin_app = 1'b0;
    status = STAT_NONE;
    segment_queue.delete();
    case (q.action)
      ACT_OPEN: begin
        if (m_state == ST_LISTEN || m_state == ST_CLOSED) begin
          m_snd_nxt = m_iss;
          m_acked = m_iss;
          m_rcv_nxt = '0;
          m_pending = 1'b0;
          m_timer = '0;
          m_state = ST_LISTEN;
          if (m_role) begin
            queue_segment(F_SYN, 16'd0);
            m_state = ST_SYNSENT;
            m_snd_nxt = m_snd_nxt + 32'd1;
          end
        end
      end
      ACT_TICK: begin
        if (is_connected() && m_pending) begin
          if (m_timer <= 16'd1) begin
            queue_segment(F_ACK, 16'd0);
            m_pending = 1'b0;
            m_timer = '0;
          end else begin
            m_timer = m_timer - 16'd1;
          end
        end
      end
      ACT_DATA: begin
        if (m_state == ST_ESTAB || m_state == ST_CLOSEWAIT) begin
          inflight = m_snd_nxt - m_acked;
          avail = (inflight >= {16'd0, m_window}) ? 32'd0 : {16'd0, m_window} - inflight;
          if (avail > {16'd0, m_mss}) avail = {16'd0, m_mss};
          if (avail > {16'd0, q.app_pending_bytes}) avail = {16'd0, q.app_pending_bytes};
          if (avail != 0) begin
            queue_segment(F_ACK, avail[15:0]);
            m_snd_nxt = m_snd_nxt + avail;
            m_pending = 1'b0;
          end
        end
      end
      ACT_SEG: begin
        if (m_state == ST_LISTEN) begin
          if (!m_role) begin
            if (q.net_flags == F_SYN) begin
              m_rcv_nxt = q.net_seq + 32'd1;
              m_state = ST_SYNRCVD;
              queue_segment(F_SYN | F_ACK, 16'd0);
              m_snd_nxt = m_snd_nxt + 32'd1;
            end else begin
              m_state = ST_CLOSED;
              status = STAT_FAILED;
            end
          end
        end else if (m_state == ST_SYNSENT) begin
          if (q.net_flags == (F_SYN | F_ACK) && q.net_ack == m_snd_nxt) begin
            m_rcv_nxt = q.net_seq + 32'd1;
            m_acked = q.net_ack;
            queue_segment(F_ACK, 16'd0);
            m_state = ST_ESTAB;
            status = STAT_CONNECTED;
          end else begin
            m_state = ST_CLOSED;
            status = STAT_FAILED;
          end
        end else if (m_state == ST_SYNRCVD) begin
          if (q.net_flags == F_ACK && q.net_ack == m_snd_nxt) begin
            m_acked = q.net_ack;
            m_state = ST_ESTAB;
            status = STAT_CONNECTED;
          end else begin
            m_state = ST_CLOSED;
            status = STAT_FAILED;
          end
        end else if (is_connected() && (q.net_flags & F_ACK) != 0) begin
          if (q.net_ack > m_acked && q.net_ack <= m_snd_nxt) begin
            m_acked = q.net_ack;
            if (m_state == ST_FINW1 && q.net_ack == m_snd_nxt) begin
              m_state = ST_FINW2;
            end else if (m_state == ST_LASTACK && q.net_ack == m_snd_nxt) begin
              m_state = ST_CLOSED;
              status = STAT_CLOSED;
            end else if (m_state == ST_CLOSING) begin
              m_state = ST_CLOSED;
              status = STAT_CLOSED;
            end
          end
          if (q.net_payload_bytes != 0) begin
            if (q.net_seq == m_rcv_nxt) begin
              deliver = q.net_payload_bytes;
              m_rcv_nxt = m_rcv_nxt + q.net_payload_bytes;
              if (m_pending) begin
                queue_segment(F_ACK, 16'd0);
                m_pending = 1'b0;
                m_timer = '0;
              end else begin
                m_pending = 1'b1;
                m_timer = m_delay;
              end
            end else begin
              m_pending = 1'b0;
              m_timer = '0;
              queue_segment(F_ACK, 16'd0);
            end
          end
          if ((q.net_flags & F_FIN) != 0 && q.net_seq + q.net_payload_bytes == m_rcv_nxt) begin
            fin_app = 1'b1;
            m_rcv_nxt = m_rcv_nxt + 32'd1;
            m_pending = 1'b0;
            m_timer = '0;
            queue_segment(F_ACK, 16'd0);
            if (m_state == ST_ESTAB) begin
              m_state = ST_CLOSEWAIT;
            end else if (m_state == ST_FINW1) begin
              m_state = ST_CLOSING;
            end else if (m_state == ST_FINW2) begin
              m_state = ST_CLOSED;
              status = STAT_CLOSED;
            end
          end
        end
      end
      ACT_CLOSE: begin
        if (is_connected()) begin
          if (m_pending) begin
            queue_segment(F_ACK, 16'd0);
            m_pending = 1'b0;
            m_timer = '0;
          end
          if (m_state == ST_ESTAB || m_state == ST_CLOSEWAIT) begin
            m_state = (m_state == ST_ESTAB) ? ST_FINW1 : ST_LASTACK;
            queue_segment(F_FIN | F_ACK, 16'd0);
            m_snd_nxt = m_snd_nxt + 32'd1;
          end
        end
      end
      default: begin
      end
    endcase
    n = (segment_queue.size() > 0) ? segment_queue.size() : 1;
    for (int k = 0; k < n; k++) begin
      r = (k < segment_queue.size()) ? segment_queue[k] : '0;
      r.link_state = m_state;
      if (k == n - 1) begin
        r.deliver_bytes = deliver;
        r.fin_to_app = fin_app;
        r.open_status = status;
        r.last = 1'b1;
      end
      expected_results.push_back(r);
    end
  endfunction

  task automatic send_request(logic [2:0] act, logic [15:0] app, logic [2:0] flags,
                              logic [31:0] seq, logic [31:0] ack, logic [15:0] len);
    req_t q;
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    q = '{act, app, flags, seq, ack, len};
    in_valid <= 1'b1;
    in_action <= act;
    in_app_pending_bytes <= app;
    in_net_flags <= flags;
    in_net_seq <= seq;
    in_net_ack <= ack;
    in_net_payload_bytes <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_connection(q);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        res_t got, want;
        got = '{out_send_valid, out_send_flags, out_tx_seq, out_send_ack, out_send_window,
                out_send_payload_bytes, out_deliver_bytes, out_fin_to_app, out_link_state,
                out_open_status, out_last};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %h actual %h", want, got);
          end
        end
        stall_left = stall_enable ? $urandom_range(0, 4) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROLE: m_role = value[0];
      CFG_WINDOW: m_window = value[15:0];
      CFG_MSS: m_mss = value[15:0];
      CFG_ISS: m_iss = value;
      CFG_DELAY: m_delay = value[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(logic role, logic [15:0] win, logic [15:0] mss, logic [31:0] iss,
                           logic [15:0] dly);
    wait_drained();
    write_register(CFG_ROLE, {31'd0, role});
    write_register(CFG_WINDOW, {16'd0, win});
    write_register(CFG_MSS, {16'd0, mss});
    write_register(CFG_ISS, iss);
    write_register(CFG_DELAY, {16'd0, dly});
    cfg_valid <= 1'b0;
  endtask

  // Brings the engine from listen or closed to established with the current role.
  task automatic handshake();
    peer_isn = $urandom;
    send_request(ACT_OPEN, '0, '0, '0, '0, '0);
    if (m_role) send_request(ACT_SEG, '0, F_SYN | F_ACK, peer_isn, m_snd_nxt, '0);
    else begin
      send_request(ACT_SEG, '0, F_SYN, peer_isn, '0, '0);
      send_request(ACT_SEG, '0, F_ACK, '0, m_snd_nxt, '0);
    end
  endtask

  task automatic random_request();
    int pick;
    logic [31:0] seq, ack;
    logic [15:0] len;
    logic [2:0] flags;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, m_mss));
    seq = ($urandom_range(0, 4) == 0) ? $urandom : m_rcv_nxt;
    ack = ($urandom_range(0, 3) == 0) ? $urandom : m_acked + $urandom_range(0, m_snd_nxt - m_acked);
    flags = F_ACK | (($urandom_range(0, 15) == 0) ? F_FIN : 3'd0) | 3'($urandom_range(0, 1));
    if (pick < 5) send_request(3'($urandom_range(0, 7)), 16'($urandom), 3'($urandom), $urandom,
                               $urandom, 16'($urandom));
    else if (pick < 25) send_request(ACT_TICK, '0, '0, '0, '0, '0);
    else if (pick < 45) send_request(ACT_DATA, 16'($urandom), '0, '0, '0, '0);
    else if (pick < 95) send_request(ACT_SEG, '0, flags, seq, ack, len);
    else send_request(ACT_CLOSE, '0, '0, '0, '0, '0);
  endtask

  task automatic test_directed();
    handshake();
    send_request(ACT_DATA, 16'hFFFF, '0, '0, '0, '0);
    send_request(ACT_DATA, 16'd0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_ACK, m_rcv_nxt, m_snd_nxt, 16'd100);
    send_request(ACT_TICK, '0, '0, '0, '0, '0);
    send_request(ACT_TICK, '0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_ACK, m_rcv_nxt, m_snd_nxt, 16'd50);
    send_request(ACT_SEG, '0, F_ACK, m_rcv_nxt, m_snd_nxt, 16'd1);
    send_request(ACT_SEG, '0, F_ACK, m_rcv_nxt + 32'd7, m_snd_nxt, 16'd1);
    send_request(ACT_SEG, '0, F_SYN, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_request(3'd7, 16'hFFFF, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_request(ACT_SEG, '0, F_ACK | F_FIN, m_rcv_nxt, m_snd_nxt, '0);
    send_request(ACT_CLOSE, '0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_ACK, '0, m_snd_nxt, '0);
    send_request(ACT_OPEN, '0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_ACK, '0, '0, '0);
    send_request(ACT_TICK, '0, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    configure(1'b1, 16'd1, 16'd1, 32'hFFFFFFFF, 16'd1);
    handshake();
    send_request(ACT_DATA, 16'd5, '0, '0, '0, '0);
    send_request(ACT_DATA, 16'd5, '0, '0, '0, '0);
    send_request(ACT_CLOSE, '0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_ACK | F_FIN, m_rcv_nxt, m_snd_nxt, '0);
    configure(1'b1, 16'hFFFF, 16'hFFFF, 32'd0, 16'hFFFF);
    send_request(ACT_OPEN, '0, '0, '0, '0, '0);
    send_request(ACT_SEG, '0, F_SYN, '0, 32'd5, '0);
    wait_drained();
  endtask

  task automatic test_random_sessions();
    int n;
    n = 0;
    while (n < 1300) begin
      configure(1'($urandom_range(0, 1)), 16'($urandom_range(1, 4000)),
                16'($urandom_range(1, 1500)), $urandom, 16'($urandom_range(1, 4)));
      if (n > 600) stall_enable = ($urandom_range(0, 1) == 0);
      handshake();
      repeat ($urandom_range(20, 80)) random_request();
      if ($urandom_range(0, 2) == 0) wait_drained();
      send_request(ACT_CLOSE, '0, '0, '0, '0, '0);
      send_request(ACT_SEG, '0, F_ACK | F_FIN, m_rcv_nxt, m_snd_nxt, '0);
      send_request(ACT_SEG, '0, F_ACK, m_rcv_nxt, m_snd_nxt, '0);
      n = requests_sent;
    end
    wait_drained();
  endtask

  initial begin
    m_role = 1'b0;
    m_window = WindowReset;
    m_mss = MssReset;
    m_iss = IssReset;
    m_delay = DelayReset;
    m_state = ST_LISTEN;
    m_snd_nxt = '0;
    m_rcv_nxt = '0;
    m_acked = '0;
    m_pending = 1'b0;
    m_timer = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_sessions();
    $display("Sent %0d requests and checked %0d results over many sessions,", requests_sent,
             results_seen);
    $display("covering both roles, window and segment size extremes, and close paths.");
    if (mismatches == 0 && expected_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
sv/rtce_pkg.sv
sv/rtce_front.sv
sv/rtce_back.sv
sv/reliable_transport_connection_engine.sv
bench/tb.sv
